### rtl/core/homogeneous_point_transform_defines.svh
// Assertion macros shared by the homogeneous point transform RTL
`ifndef HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH
`ifndef SYNTH
`define HPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HPT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HPT_ASSERT(lbl, prop, msg)
`define HPT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### rtl/core/hpt_pkg.sv
// Types, command bundle and helpers for the homogeneous point transform
package hpt_pkg;

  localparam int NUM_COEF = 16;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_PROJ   = 2'd1,
    ACT_AFFINE = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DOT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SCALE,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_ADDP,
    ACC_ADDC
  } acc_op_t;

  typedef enum logic {
    MUL_PT,
    MUL_RES
  } mul_src_t;

  typedef struct packed {
    logic       load_pt;
    logic       coef_wr;
    logic [3:0] coef_addr;
    logic       mul_en;
    mul_src_t   mul_src;
    logic [1:0] mul_sel;
    acc_op_t    acc_op;
    logic       st_en;
    logic [1:0] st_row;
    logic       sc_en;
    logic [1:0] sc_row;
    logic       div_start;
    logic       zero_out;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic acc_zero;
    logic div_done;
  } sts_t;

  function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) return 32'h8000_0000;
    else return v[DATA_W-1:0];
  endfunction

endpackage

### rtl/core/hpt_recip.sv
// Iterative reciprocal (1 << 2*FRAC_BITS) / w, one quotient bit per cycle
module hpt_recip #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] w,
  output logic        done,
  output logic [31:0] inv
);

  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int CW = $clog2(QW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [31:0]   dvs;
  logic          neg;
  logic [31:0]   rem;
  logic [QW-1:0] quo;
  logic [32:0]   trial;
  logic          ge;
  logic [63:0]   q64;

  // numerator has a single one at bit 2*FRAC_BITS, the first bit taken
  assign trial = {rem, (cnt == CW'(QW))};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= w[31];
      dvs <= w[31] ? (~w + 32'd1) : w;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? 32'(trial - {1'b0, dvs}) : trial[31:0];
      quo <= {quo[QW-2:0], ge};
    end
  end

  assign q64 = 64'(quo);

  always_comb begin
    if (!neg) inv = (q64 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q64[31:0];
    else      inv = (q64 > 64'h8000_0000) ? 32'h8000_0000 : (~q64[31:0] + 32'd1);
  end

endmodule

### rtl/core/hpt_dpath.sv
// Datapath: coefficient store, shared multiplier, accumulator, result registers
module hpt_dpath #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  hpt_pkg::cmd_t      cmd,
  output hpt_pkg::sts_t      sts,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  output logic [31:0]        out_x,
  output logic [31:0]        out_y,
  output logic [31:0]        out_z,
  output logic               w_was_zero
);

  logic signed [31:0] coef [hpt_pkg::NUM_COEF];
  logic signed [31:0] x, y, z;
  logic signed [31:0] res0, res1, res2;
  logic signed [31:0] ws;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] fl;
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] coef_rd;
  logic               wzero;
  logic               div_done;
  logic [31:0]        inv;

  hpt_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .w     (ws),
    .done  (div_done),
    .inv   (inv)
  );

  assign coef_rd = coef[cmd.coef_addr];
  assign fl      = prod >>> FRAC_BITS;

  always_comb begin
    if (cmd.mul_src == hpt_pkg::MUL_PT) begin
      mul_a = coef_rd;
      case (cmd.mul_sel)
        2'd0:    mul_b = x;
        2'd1:    mul_b = y;
        default: mul_b = z;
      endcase
    end else begin
      mul_b = inv;
      case (cmd.mul_sel)
        2'd0:    mul_a = res0;
        2'd1:    mul_a = res1;
        default: mul_a = res2;
      endcase
    end
  end

  // identity on the diagonal after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hpt_pkg::NUM_COEF; i++) begin
        coef[i] <= (i % 5 == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
      end
    end else if (cmd.coef_wr) begin
      coef[coef_index] <= coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wzero <= 1'b0;
    end else if (cmd.load_pt) begin
      wzero <= 1'b0;
    end else if (cmd.zero_out) begin
      wzero <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      x <= px;
      y <= py;
      z <= pz;
    end
    if (cmd.mul_en) prod <= mul_a * mul_b;
    case (cmd.acc_op)
      hpt_pkg::ACC_CLR:  acc <= '0;
      hpt_pkg::ACC_ADDP: acc <= acc + fl;
      hpt_pkg::ACC_ADDC: acc <= acc + {{32{coef_rd[31]}}, coef_rd};
      default:           acc <= acc;
    endcase
    if (cmd.st_en) begin
      case (cmd.st_row)
        2'd0:    res0 <= hpt_pkg::sat32(acc);
        2'd1:    res1 <= hpt_pkg::sat32(acc);
        2'd2:    res2 <= hpt_pkg::sat32(acc);
        default: ws   <= hpt_pkg::sat32(acc);
      endcase
    end
    if (cmd.sc_en) begin
      case (cmd.sc_row)
        2'd0:    res0 <= hpt_pkg::sat32(fl);
        2'd1:    res1 <= hpt_pkg::sat32(fl);
        default: res2 <= hpt_pkg::sat32(fl);
      endcase
    end
    if (cmd.out_load) begin
      out_x      <= wzero ? '0 : res0;
      out_y      <= wzero ? '0 : res1;
      out_z      <= wzero ? '0 : res2;
      w_was_zero <= wzero;
    end
  end

  assign sts.acc_zero = (acc == '0);
  assign sts.div_done = div_done;

endmodule

### rtl/core/hpt_ctrl.sv
// Controller: sequences dot products, reciprocal and scaling per beat
`include "homogeneous_point_transform_defines.svh"
module hpt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [1:0]    action,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  hpt_pkg::sts_t sts,
  output hpt_pkg::cmd_t cmd
);

  hpt_pkg::state_t state, state_next;
  logic       proj, proj_next;
  logic [1:0] row, row_next;
  logic [2:0] k, k_next;
  logic       m_tvalid_next;
  logic [1:0] kk;

  assign kk = (k == 3'd4) ? 2'd3 : k[1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hpt_pkg::S_IDLE;
      proj     <= 1'b0;
      row      <= '0;
      k        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      proj     <= proj_next;
      row      <= row_next;
      k        <= k_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next    = state;
    proj_next     = proj;
    row_next      = row;
    k_next        = k;
    m_tvalid_next = m_tvalid && !m_tready;
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.mul_src   = hpt_pkg::MUL_PT;
    cmd.acc_op    = hpt_pkg::ACC_HOLD;
    // projective reads columns (row + 4k), affine reads rows (4row + k)
    cmd.coef_addr = proj ? {kk, row} : {row, kk};
    case (state)
      hpt_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (action)
            hpt_pkg::ACT_LOAD: cmd.coef_wr = 1'b1;
            hpt_pkg::ACT_PROJ: begin
              cmd.load_pt = 1'b1;
              proj_next   = 1'b1;
              row_next    = 2'd3;
              k_next      = '0;
              state_next  = hpt_pkg::S_DOT;
            end
            hpt_pkg::ACT_AFFINE: begin
              cmd.load_pt = 1'b1;
              proj_next   = 1'b0;
              row_next    = 2'd0;
              k_next      = '0;
              state_next  = hpt_pkg::S_DOT;
            end
            default: ;
          endcase
        end
      end
      hpt_pkg::S_DOT: begin
        k_next = k + 3'd1;
        if (k < 3'd3) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = k[1:0];
        end
        case (k)
          3'd0:    cmd.acc_op = hpt_pkg::ACC_CLR;
          3'd1, 3'd2, 3'd3: cmd.acc_op = hpt_pkg::ACC_ADDP;
          3'd4:    cmd.acc_op = hpt_pkg::ACC_ADDC;
          default: begin
            cmd.st_en  = 1'b1;
            cmd.st_row = row;
            k_next     = '0;
            if (proj && row == 2'd3) begin
              if (sts.acc_zero) begin
                cmd.zero_out = 1'b1;
                state_next   = hpt_pkg::S_OUT;
              end else begin
                state_next = hpt_pkg::S_DIV_GO;
              end
            end else if (row == 2'd2) begin
              state_next = proj ? hpt_pkg::S_SCALE : hpt_pkg::S_OUT;
            end else begin
              row_next = row + 2'd1;
            end
          end
        endcase
      end
      hpt_pkg::S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = hpt_pkg::S_DIV_WAIT;
      end
      hpt_pkg::S_DIV_WAIT: begin
        if (sts.div_done) begin
          row_next   = 2'd0;
          k_next     = '0;
          state_next = hpt_pkg::S_DOT;
        end
      end
      hpt_pkg::S_SCALE: begin
        k_next      = k + 3'd1;
        cmd.mul_src = hpt_pkg::MUL_RES;
        cmd.mul_sel = k[1:0];
        cmd.mul_en  = (k < 3'd3);
        cmd.sc_en   = (k != 3'd0);
        cmd.sc_row  = 2'(k - 3'd1);
        if (k == 3'd3) begin
          k_next     = '0;
          state_next = hpt_pkg::S_OUT;
        end
      end
      hpt_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = hpt_pkg::S_IDLE;
        end
      end
      default: state_next = hpt_pkg::S_IDLE;
    endcase
  end

  `HPT_ASSERT(a_div_resumes, state == hpt_pkg::S_DIV_WAIT && sts.div_done |=> state == hpt_pkg::S_DOT && row == 2'd0, "dot rows do not resume after reciprocal")
  `HPT_ASSERT(a_no_clobber, cmd.out_load |-> !m_tvalid || m_tready, "result overwritten before taken")
  `HPT_ASSERT_RST(a_rst_quiet, rst |=> state == hpt_pkg::S_IDLE && !m_tvalid, "not idle after reset")

endmodule

### rtl/core/homogeneous_point_transform.sv
// An accepted affine or projective beat gives one result on m_tvalid; a projective beat
// whose w is zero skips the reciprocal and scaling; a load beat gives no result.
// One beat in flight, next one taken once the result registers load; load beats are
// taken one per cycle. Each dot row runs on the shared 32x32 multiplier, and projective
// points also wait on the bit-serial reciprocal.
// Synchronous active-high reset restores the identity matrix and empties outputs.
`include "homogeneous_point_transform_defines.svh"
module homogeneous_point_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,  // coef_index[3:0], coef_value, px, py, pz, zero pad
  input  logic [1:0]   s_tuser,  // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,  // out_x, out_y, out_z
  output logic [0:0]   m_tuser   // w_was_zero
);

  hpt_pkg::cmd_t cmd;
  hpt_pkg::sts_t sts;
  logic [31:0] out_x, out_y, out_z;
  logic        w_was_zero;

  hpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .action   (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hpt_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .coef_index (s_tdata[3:0]),
    .coef_value (s_tdata[35:4]),
    .px         (s_tdata[67:36]),
    .py         (s_tdata[99:68]),
    .pz         (s_tdata[131:100]),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .w_was_zero (w_was_zero)
  );

  assign m_tdata = {out_z, out_y, out_x};
  assign m_tuser = w_was_zero;

  `HPT_ASSERT(a_zero_w_clears, m_tvalid && m_tuser[0] |-> m_tdata == '0, "zero w with nonzero data")

endmodule

### bench/hpt_checker.sv
// Stream monitor and result predictor for the homogeneous point transform
`timescale 1ns / 100ps
module hpt_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [135:0] s_tdata,  // coef_index, coef_value, px, py, pz, zero pad
  input  logic [1:0]   s_tuser,  // action
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [95:0]  m_tdata,  // out_x, out_y, out_z
  input  logic [0:0]   m_tuser,  // w_was_zero
  output int           errors,
  output int           pending,
  output int           n_results,
  output int           n_wzero
);

  localparam int FRAC = 16;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        wz;
  } point_out_t;

  logic signed [31:0] matrix [hpt_pkg::NUM_COEF];
  point_out_t         point_q [$];

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // exact product, floored by the fraction width
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> FRAC;
  endfunction

  function automatic logic signed [63:0] row_sum(input logic signed [63:0] x,
      input logic signed [63:0] y, input logic signed [63:0] z,
      input int a, input int b, input int c, input int d);
    return fx_mul(x, 64'(matrix[a])) + fx_mul(y, 64'(matrix[b])) +
           fx_mul(z, 64'(matrix[c])) + 64'(matrix[d]);
  endfunction

  function automatic point_out_t transform_point(input hpt_pkg::action_t act,
      input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] pz);
    point_out_t r;
    logic signed [63:0] x, y, z, w, inv, rx, ry, rz;
    x = 64'(px); y = 64'(py); z = 64'(pz);
    r = '0;
    if (act == hpt_pkg::ACT_AFFINE) begin
      r.x = 32'(clamp32(row_sum(x, y, z, 0, 1, 2, 3)));
      r.y = 32'(clamp32(row_sum(x, y, z, 4, 5, 6, 7)));
      r.z = 32'(clamp32(row_sum(x, y, z, 8, 9, 10, 11)));
    end else begin
      w = row_sum(x, y, z, 3, 7, 11, 15);
      if (w == 0) begin
        r.wz = 1'b1;
      end else begin
        inv = clamp32((64'sd1 <<< (2 * FRAC)) / clamp32(w));
        rx = clamp32(row_sum(x, y, z, 0, 4, 8, 12));
        ry = clamp32(row_sum(x, y, z, 1, 5, 9, 13));
        rz = clamp32(row_sum(x, y, z, 2, 6, 10, 14));
        r.x = 32'(clamp32(fx_mul(rx, inv)));
        r.y = 32'(clamp32(fx_mul(ry, inv)));
        r.z = 32'(clamp32(fx_mul(rz, inv)));
      end
    end
    return r;
  endfunction

  assign pending = point_q.size();

  initial begin
    errors = 0;
    n_results = 0;
    n_wzero = 0;
  end

  always @(posedge clk) begin
    point_out_t want, got;
    if (rst) begin
      for (int i = 0; i < hpt_pkg::NUM_COEF; i++) matrix[i] <= (i % 5 == 0) ? 32'sd65536 : 32'sd0;
    end else begin
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          hpt_pkg::ACT_LOAD: matrix[s_tdata[3:0]] <= s_tdata[35:4];
          hpt_pkg::ACT_PROJ, hpt_pkg::ACT_AFFINE:
            point_q.push_back(transform_point(hpt_pkg::action_t'(s_tuser), s_tdata[67:36],
                                              s_tdata[99:68], s_tdata[131:100]));
          default: ;  // unused selector: dropped
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0]};
        n_results++;
        if (point_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat %h", $time, got);
        end else begin
          want = point_q.pop_front();
          if (want.wz) n_wzero++;
          if (got.x !== want.x) begin
            errors++;
            $display("%0t: out_x expected %h actual %h", $time, want.x, got.x);
          end
          if (got.y !== want.y) begin
            errors++;
            $display("%0t: out_y expected %h actual %h", $time, want.y, got.y);
          end
          if (got.z !== want.z) begin
            errors++;
            $display("%0t: out_z expected %h actual %h", $time, want.z, got.z);
          end
          if (got.wz !== want.wz) begin
            errors++;
            $display("%0t: w_was_zero expected %b actual %b", $time, want.wz, got.wz);
          end
        end
      end
    end
  end

endmodule

### bench/tb_homogeneous_point_transform.sv
// Stimulus, flow control and verdict for the homogeneous point transform
`timescale 1ns / 100ps
module tb_homogeneous_point_transform;

  localparam int N_RANDOM    = 1080;
  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_WAIT  = 120;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;  // coef_index, coef_value, px, py, pz, zero pad
  logic [1:0]   s_tuser;  // action
  logic         m_tvalid;
  logic         m_tready;
  logic [95:0]  m_tdata;  // out_x, out_y, out_z
  logic [0:0]   m_tuser;  // w_was_zero

  int errors, pending, n_results, n_wzero;
  int send_idle_pct, recv_stall_pct, hold_off;
  int cycles, n_sent;

  homogeneous_point_transform u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  hpt_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending), .n_results(n_results), .n_wzero(n_wzero)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_homogeneous_point_transform: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] rand_fix();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2:    return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;  // about +-8.0
      3:    return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      4: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0001_0000;
          3: return 32'hFFFF_0000;
          default: return 32'h0;
        endcase
      end
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  // drive one beat and hold it until accepted
  task automatic send_beat(input logic [1:0] act, input logic [3:0] idx,
                           input logic [31:0] cv, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = {4'h0, z, y, x, cv, idx};
    do @(posedge clk); while (!s_tready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic load_coef(input int idx, input logic [31:0] v);
    send_beat(hpt_pkg::ACT_LOAD, idx[3:0], v, $urandom, $urandom, $urandom);
  endtask

  task automatic send_point(input logic [1:0] act, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z);
    send_beat(act, 4'($urandom), $urandom, x, y, z);
  endtask

  initial begin
    logic [1:0] act;
    int         pick;
    cycles = 0; n_sent = 0; hold_off = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = '0;
    s_tdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // identity matrix, extreme points, both transforms
    send_point(hpt_pkg::ACT_AFFINE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    send_point(hpt_pkg::ACT_PROJ, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_point(hpt_pkg::ACT_UNUSED, $urandom, $urandom, $urandom);  // ignored selector
    // saturating affine row
    load_coef(0, 32'h7FFF_FFFF);
    load_coef(1, 32'h7FFF_FFFF);
    send_point(hpt_pkg::ACT_AFFINE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    // w forced to zero
    load_coef(15, 32'h0);
    send_point(hpt_pkg::ACT_PROJ, 32'h0003_0000, 32'h0002_0000, 32'h1234_5678);
    // w of minus one LSB and of one LSB
    load_coef(15, 32'hFFFF_FFFF);
    send_point(hpt_pkg::ACT_PROJ, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    load_coef(15, 32'h0000_0001);
    send_point(hpt_pkg::ACT_PROJ, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000);
    load_coef(3, 32'h8000_0000);
    load_coef(15, 32'h7FFF_FFFF);
    send_point(hpt_pkg::ACT_PROJ, 32'h0000_8000, 32'h0001_0000, 32'h0002_0000);
    send_point(hpt_pkg::ACT_AFFINE, 32'h0, 32'h0, 32'h0);

    // long output hold-off while input keeps coming
    hold_off = 400;
    for (int i = 0; i < 6; i++) begin
      send_point(hpt_pkg::ACT_AFFINE, rand_fix(), rand_fix(), rand_fix());
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          // clear the w column so projective w comes out zero
          load_coef(3, 0); load_coef(7, 0); load_coef(11, 0); load_coef(15, 0);
        end else if (pick < 36) begin
          load_coef($urandom_range(0, 15), rand_fix());
        end else begin
          act = (pick < 40) ? hpt_pkg::ACT_UNUSED :
                (pick < 70) ? hpt_pkg::ACT_PROJ : hpt_pkg::ACT_AFFINE;
          send_point(act, rand_fix(), rand_fix(), rand_fix());
        end
        if (ph == 0 && i == 150) hold_off = 300;
      end
    end

    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Sent %0d beats; checked %0d results (%0d with zero w).",
             n_sent, n_results, n_wzero);
    $display("Covered loads, projective and affine points, idle and stall mixes.");
    if (errors == 0 && pending == 0) begin
      $display("tb_homogeneous_point_transform: done, clean");
    end else begin
      $display("tb_homogeneous_point_transform: done, errors");
    end
    $finish;
  end

endmodule

### homogeneous_point_transform.f
+incdir+rtl/core
rtl/core/hpt_pkg.sv
rtl/core/hpt_recip.sv
rtl/core/hpt_dpath.sv
rtl/core/hpt_ctrl.sv
rtl/core/homogeneous_point_transform.sv
bench/hpt_checker.sv
bench/tb_homogeneous_point_transform.sv
